// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file nau_checker.
// No dependencies; the caller must have clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// consequent must follow the antecedent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold a fixed number of cycles after the antecedent
`define ASSERT_DELAYED(label, ante, cycles, cons) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##cycles (cons)) else $error("assertion failed");

`endif

// ===== sv/nau_pkg.sv =====
// Types and constants of the neural activation unit.
// No dependencies; used by every module of the block.
package nau_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // activation codes held in the function select register
   localparam logic [1:0] FUNC_SIGMOID = 2'd0;
   localparam logic [1:0] FUNC_TANH    = 2'd1;
   localparam logic [1:0] FUNC_RELU    = 2'd2;

   // register indexes, taken from address bit 2
   localparam logic REG_FUNC_SEL   = 1'b0;
   localparam logic REG_DERIV_MODE = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] x_value;
      logic                           last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] y_value;
      logic                           last_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0] function_select;
      logic       derivative_mode;
   } cfg_type;

endpackage

// ===== sv/neural_activation_unit.sv =====
// Top level of the neural activation unit: registers and two pipelines.
// Depends on nau_pkg, nau_csr, nau_sigmoid and nau_post.
//
//   channel   ports                         transfer when
//   request   start, busy, req_data         start && !busy
//   result    rsp_valid, rsp_data           rsp_valid (one cycle)
//   config    psel ... pready, paddr        psel && penable && pwrite
//
// One sample per cycle; each result is transferred once its sample has passed the
// five register stages: fold and grid multiply, table read, interpolation multiply,
// derivative multiply, output register.
// Synchronous reset clears the configuration registers and all valid bits.
// Results cannot be held off, so nothing stalls and busy stays low.
module neural_activation_unit #(
   parameter int FRAC_BITS      = 12,
   parameter int TABLE_SEGMENTS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  nau_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output nau_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [nau_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nau_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nau_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   nau_pkg::cfg_type   cfg;
   logic               sig_valid;
   logic [FRAC_BITS:0] sig_value;
   nau_pkg::req_type   sig_item;

   assign busy = 1'b0;

   nau_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   nau_sigmoid #(
      .FRAC_BITS      (FRAC_BITS),
      .TABLE_SEGMENTS (TABLE_SEGMENTS)
   ) u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (start && !busy),
      .in_item   (req_data),
      .out_valid (sig_valid),
      .out_value (sig_value),
      .out_item  (sig_item)
   );

   nau_post #(
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (sig_valid),
      .in_value  (sig_value),
      .in_item   (sig_item),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/nau_csr.sv =====
// Configuration registers behind the APB-style port.
// Depends on nau_pkg for the register codes and the cfg_type bundle.
module nau_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [nau_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nau_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nau_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output nau_pkg::cfg_type                 cfg
);

   logic [1:0] func_sel_ff, func_sel_in;
   logic       deriv_ff, deriv_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      func_sel_in = func_sel_ff;
      deriv_in    = deriv_ff;
      if (wr_en) begin
         unique case (paddr[2])
            nau_pkg::REG_FUNC_SEL:   func_sel_in = pwdata[1:0];
            nau_pkg::REG_DERIV_MODE: deriv_in    = pwdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         func_sel_ff <= nau_pkg::FUNC_SIGMOID;
         deriv_ff    <= 1'b0;
      end else begin
         func_sel_ff <= func_sel_in;
         deriv_ff    <= deriv_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         nau_pkg::REG_FUNC_SEL:   prdata = nau_pkg::CSR_DATA_W'(func_sel_ff);
         nau_pkg::REG_DERIV_MODE: prdata = nau_pkg::CSR_DATA_W'(deriv_ff);
      endcase
   end

   assign cfg.function_select = func_sel_ff;
   assign cfg.derivative_mode = deriv_ff;

endmodule

// ===== sv/nau_sigmoid.sv =====
// Sigmoid pipeline: argument fold, table read and linear interpolation.
// Depends on nau_pkg for the item and configuration types.
module nau_sigmoid #(
   parameter int FRAC_BITS      = 12,
   parameter int TABLE_SEGMENTS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nau_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   input  nau_pkg::req_type     in_item,
   output logic                 out_valid,
   output logic [FRAC_BITS:0]   out_value,
   output nau_pkg::req_type     out_item
);

   localparam int ARG_W  = nau_pkg::SAMPLE_WIDTH + 1;
   localparam int ENT_W  = FRAC_BITS + 1;
   localparam int REM_W  = FRAC_BITS + 3;
   localparam int SEG_W  = $clog2(TABLE_SEGMENTS + 1);
   localparam int POS_W  = REM_W + SEG_W;
   localparam int PROD_W = ENT_W + REM_W;

   localparam logic [ARG_W:0]     SPAN      = (ARG_W + 1)'(1) << REM_W;
   localparam logic [SEG_W-1:0]   SEG_C     = SEG_W'(TABLE_SEGMENTS);
   localparam logic [ENT_W-1:0]   ONE       = ENT_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0]  HALF_SPAN = PROD_W'(1) << (REM_W - 1);

   // restoring division, elaboration only
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // sigmoid at 8k/TABLE_SEGMENTS, via a series for exp(-8/TABLE_SEGMENTS)
   function automatic logic [63:0] rom_entry(input int k);
      logic [63:0] q, base, term, p, den, num;
      q    = 64'd1 << 32;
      base = q;
      term = q;
      p    = q;
      for (int n = 1; n < 32; n++) begin
         term = udiv(term * 64'd8, 64'(TABLE_SEGMENTS) * 64'(n));
         if (n[0]) base = base - term;
         else      base = base + term;
      end
      for (int j = 0; j < k; j++) begin
         p = (p * base + (64'd1 << 31)) >> 32;
      end
      den = q + p;
      num = 64'd1 << (32 + FRAC_BITS);
      return udiv(num + (den >> 1), den);
   endfunction

   logic [ENT_W-1:0] rom_tbl [TABLE_SEGMENTS+1];

   for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_rom
      localparam logic [63:0] ENTRY = rom_entry(k);
      assign rom_tbl[k] = ENTRY[ENT_W-1:0];
   end

   // stage 1: fold the sign and scale onto the table grid
   logic                 s1_valid_ff, s1_valid_in;
   logic [POS_W-1:0]     s1_pos_ff, s1_pos_in;
   logic                 s1_neg_ff, s1_neg_in;
   logic                 s1_sat_ff, s1_sat_in;
   nau_pkg::req_type     s1_item_ff, s1_item_in;
   logic [ARG_W-1:0]     arg_w;
   logic [ARG_W-1:0]     mag_w;

   always_comb begin
      s1_valid_in = in_valid;
      s1_item_in  = in_item;
      if (cfg.function_select == nau_pkg::FUNC_TANH) begin
         arg_w = {in_item.x_value, 1'b0};
      end else begin
         arg_w = {in_item.x_value[nau_pkg::SAMPLE_WIDTH-1], in_item.x_value};
      end
      s1_neg_in = arg_w[ARG_W-1];
      mag_w     = s1_neg_in ? (~arg_w + ARG_W'(1)) : arg_w;
      s1_sat_in = {1'b0, mag_w} >= SPAN;
      s1_pos_in = POS_W'(mag_w[REM_W-1:0]) * POS_W'(SEG_C);
   end

   // stage 2: read the two neighbouring entries
   logic                 s2_valid_ff, s2_valid_in;
   logic [ENT_W-1:0]     s2_lo_ff, s2_lo_in;
   logic [ENT_W-1:0]     s2_diff_ff, s2_diff_in;
   logic [REM_W-1:0]     s2_rem_ff, s2_rem_in;
   logic                 s2_neg_ff, s2_neg_in;
   logic                 s2_sat_ff, s2_sat_in;
   nau_pkg::req_type     s2_item_ff, s2_item_in;
   logic [SEG_W-1:0]     idx_w, idx_next_w;
   logic [ENT_W-1:0]     hi_w;

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_item_in  = s1_item_ff;
      s2_neg_in   = s1_neg_ff;
      s2_sat_in   = s1_sat_ff;
      idx_w       = s1_pos_ff[POS_W-1:REM_W];
      idx_next_w  = idx_w + SEG_W'(1);
      s2_rem_in   = s1_pos_ff[REM_W-1:0];
      s2_lo_in    = rom_tbl[idx_w];
      hi_w        = rom_tbl[idx_next_w];
      s2_diff_in  = hi_w - s2_lo_in;
   end

   // stage 3: interpolate, round, saturate and mirror
   logic                 s3_valid_ff, s3_valid_in;
   logic [ENT_W-1:0]     s3_value_ff, s3_value_in;
   nau_pkg::req_type     s3_item_ff, s3_item_in;
   logic [PROD_W-1:0]    prod_w;
   logic [ENT_W-1:0]     step_w;
   logic [ENT_W-1:0]     mag_s_w;

   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_item_in  = s2_item_ff;
      prod_w      = PROD_W'(s2_diff_ff) * PROD_W'(s2_rem_ff) + HALF_SPAN;
      step_w      = prod_w[PROD_W-1:REM_W];
      mag_s_w     = s2_sat_ff ? ONE : (s2_lo_ff + step_w);
      s3_value_in = s2_neg_ff ? (ONE - mag_s_w) : mag_s_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff   <= s1_pos_in;
      s1_neg_ff   <= s1_neg_in;
      s1_sat_ff   <= s1_sat_in;
      s1_item_ff  <= s1_item_in;
      s2_lo_ff    <= s2_lo_in;
      s2_diff_ff  <= s2_diff_in;
      s2_rem_ff   <= s2_rem_in;
      s2_neg_ff   <= s2_neg_in;
      s2_sat_ff   <= s2_sat_in;
      s2_item_ff  <= s2_item_in;
      s3_value_ff <= s3_value_in;
      s3_item_ff  <= s3_item_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_value = s3_value_ff;
   assign out_item  = s3_item_ff;

endmodule

// ===== sv/nau_post.sv =====
// Output pipeline: tanh mapping, derivative product and result select.
// Depends on nau_pkg for the item, result and configuration types.
module nau_post #(
   parameter int FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nau_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   input  logic [FRAC_BITS:0]   in_value,
   input  nau_pkg::req_type     in_item,
   output logic                 rsp_valid,
   output nau_pkg::rsp_type     rsp_data
);

   localparam int ENT_W = FRAC_BITS + 1;
   localparam int T_W   = FRAC_BITS + 2;
   localparam int PR_W  = 2 * T_W;
   localparam int SW    = nau_pkg::SAMPLE_WIDTH;

   localparam logic [ENT_W-1:0] ONE      = ENT_W'(1) << FRAC_BITS;
   localparam logic [PR_W-1:0]  HALF_ONE = PR_W'(1) << (FRAC_BITS - 1);

   // stage 4: t = 2s - 1 and the single derivative multiplier
   logic                     s4_valid_ff, s4_valid_in;
   logic signed [PR_W-1:0]   s4_prod_ff, s4_prod_in;
   logic [ENT_W-1:0]         s4_s_ff, s4_s_in;
   logic signed [T_W-1:0]    s4_t_ff, s4_t_in;
   nau_pkg::req_type         s4_item_ff, s4_item_in;
   logic [T_W:0]             t_wide_w;
   logic signed [T_W-1:0]    op_a_w, op_b_w;

   always_comb begin
      s4_valid_in = in_valid;
      s4_item_in  = in_item;
      s4_s_in     = in_value;
      t_wide_w    = {1'b0, in_value, 1'b0} - (T_W + 1)'(ONE);
      s4_t_in     = $signed(t_wide_w[T_W-1:0]);
      if (cfg.function_select == nau_pkg::FUNC_TANH) begin
         op_a_w = s4_t_in;
         op_b_w = s4_t_in;
      end else begin
         op_a_w = $signed({1'b0, in_value});
         op_b_w = $signed({1'b0, ONE - in_value});
      end
      s4_prod_in = PR_W'(op_a_w) * PR_W'(op_b_w);
   end

   // stage 5: round the product and pick the result
   logic                     rsp_valid_ff, rsp_valid_in;
   nau_pkg::rsp_type         rsp_ff, rsp_in;
   logic [PR_W-1:0]          sum_w;
   logic [PR_W-FRAC_BITS-1:0] rnd_w;
   logic                     x_pos_w;

   always_comb begin
      rsp_valid_in    = s4_valid_ff;
      rsp_in.last_out = s4_item_ff.last_in;
      sum_w           = $unsigned(s4_prod_ff) + HALF_ONE;
      rnd_w           = sum_w[PR_W-1:FRAC_BITS];
      x_pos_w         = !s4_item_ff.x_value[SW-1] && (|s4_item_ff.x_value);
      unique case (cfg.function_select)
         nau_pkg::FUNC_SIGMOID: begin
            if (cfg.derivative_mode) rsp_in.y_value = $signed(SW'(rnd_w));
            else                     rsp_in.y_value = $signed(SW'(s4_s_ff));
         end
         nau_pkg::FUNC_TANH: begin
            if (cfg.derivative_mode) rsp_in.y_value = $signed(SW'(ONE) - SW'(rnd_w));
            else                     rsp_in.y_value = SW'(s4_t_ff);
         end
         nau_pkg::FUNC_RELU: begin
            if (!x_pos_w)                rsp_in.y_value = '0;
            else if (cfg.derivative_mode) rsp_in.y_value = $signed(SW'(ONE));
            else                          rsp_in.y_value = s4_item_ff.x_value;
         end
         default: rsp_in.y_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_prod_ff <= s4_prod_in;
      s4_s_ff    <= s4_s_in;
      s4_t_ff    <= s4_t_in;
      s4_item_ff <= s4_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/nau_checker.sv =====
// Port-level checks of the neural activation unit, bound to the top level.
// Depends on nau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nau_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  nau_pkg::req_type                 req_data,
   input  logic                             rsp_valid,
   input  nau_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [nau_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [nau_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic [nau_pkg::CSR_DATA_W-1:0]   prdata,
   input  logic                             pready
);

   logic accept;
   assign accept = start && !busy;

   `ASSERT_ALWAYS(a_pready_high, pready)
   `ASSERT_DELAYED(a_result_follows, accept, 5, rsp_valid)
   `ASSERT_IMPLIES(a_result_has_transfer, rsp_valid, $past(accept, 5))
   `ASSERT_IMPLIES(a_last_kept, rsp_valid, rsp_data.last_out == $past(req_data.last_in, 5))

endmodule

bind neural_activation_unit nau_checker u_checker (.*);
